[rtl/gbts_pkg.sv]
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared constants, command and status codes, and the result bundle of the
// gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);        // store address bits
    localparam int CW       = $clog2(CAPACITY + 1);    // count bits (0..CAPACITY)
    localparam int SW       = (CW + 2 > 18) ? CW + 2 : 18;  // signed compare/sum bits

    // Command codes
    localparam logic [2:0] CMD_MOVE    = 3'd0;
    localparam logic [2:0] CMD_ADVANCE = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_NODEL = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    // One result item from the core
    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] status;
        logic [6:0] text_length;
        logic [6:0] cursor_pos;
    } gbts_res_t;

endpackage

[rtl/gbts_ram.sv]
// ----------------------------------------------------------------------------
// gbts_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/gbts_core.sv]
// ----------------------------------------------------------------------------
// gbts_core
// Command sequencer of the gap buffer: cursor and length bookkeeping, the
// one-character-per-cycle gap relocation, and the store accesses.
// ----------------------------------------------------------------------------
module gbts_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_cmd,
    input  logic signed [15:0]      s_position,
    input  logic [7:0]              s_char_in,
    output logic                    res_valid,
    input  logic                    res_take,
    output gbts_pkg::gbts_res_t     res
);

    localparam int AW = gbts_pkg::AW;
    localparam int CW = gbts_pkg::CW;
    localparam int SW = gbts_pkg::SW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_OP    = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [7:0]    ch_reg, ch_next;
    logic [CW-1:0] gf_reg, gf_next;      // gap first
    logic [CW-1:0] ga_reg, ga_next;      // gap after
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] len_reg, len_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]    res_char_reg, res_char_next;
    logic [1:0]    res_status_reg, res_status_next;

    // store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // arithmetic helpers
    logic signed [SW-1:0] pos_ext;
    logic signed [SW-1:0] len_ext;
    logic signed [SW-1:0] cur_ext;
    logic signed [SW-1:0] tgt;
    logic [CW-1:0]        tgt_clamped;
    logic                 read_oob;
    logic [CW-1:0]        read_pos;
    logic [CW-1:0]        read_phys;
    logic [CW-1:0]        gf_dec;
    logic [CW-1:0]        ga_dec;

    gbts_ram #(
        .DEPTH (gbts_pkg::CAPACITY),
        .WIDTH (8)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // position extension, cursor target and clamp to 0..length
    always_comb begin
        pos_ext = {{(SW-16){s_position[15]}}, s_position};
        len_ext = {{(SW-CW){1'b0}}, len_reg};
        cur_ext = {{(SW-CW){1'b0}}, cur_reg};
        tgt     = (s_cmd == gbts_pkg::CMD_ADVANCE) ? cur_ext + pos_ext : pos_ext;
        if (tgt[SW-1]) begin
            tgt_clamped = '0;
        end else if (tgt > len_ext) begin
            tgt_clamped = len_reg;
        end else begin
            tgt_clamped = tgt[CW-1:0];
        end
        read_oob  = pos_ext[SW-1] || (pos_ext >= len_ext);
        read_pos  = pos_ext[CW-1:0];
        read_phys = (read_pos < gf_reg) ? read_pos : read_pos + (ga_reg - gf_reg);
        gf_dec    = gf_reg - 1'b1;
        ga_dec    = ga_reg - 1'b1;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        gf_next         = gf_reg;
        ga_next         = ga_reg;
        cur_next        = cur_reg;
        len_next        = len_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        res_char_next   = res_char_reg;
        res_status_next = res_status_reg;
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = s_cmd;
                    ch_next         = s_char_in;
                    res_char_next   = '0;
                    res_status_next = gbts_pkg::STAT_OK;
                    state_next      = ST_DONE;
                    case (s_cmd)
                        gbts_pkg::CMD_MOVE, gbts_pkg::CMD_ADVANCE: begin
                            cur_next = tgt_clamped;
                        end
                        gbts_pkg::CMD_INSERT: begin
                            state_next = ST_SHIFT;
                        end
                        gbts_pkg::CMD_DELETE: begin
                            if (cur_reg == '0) begin
                                res_status_next = gbts_pkg::STAT_NODEL;
                            end else begin
                                state_next = ST_SHIFT;
                            end
                        end
                        gbts_pkg::CMD_READ: begin
                            if (read_oob) begin
                                res_status_next = gbts_pkg::STAT_RANGE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = read_phys[AW-1:0];
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            // unused codes: no operation
                        end
                    endcase
                end
            end

            // move the gap one character per cycle; write lags read by one character
            ST_SHIFT: begin
                wr_en           = pend_valid_reg;
                pend_valid_next = 1'b0;
                if (gf_reg < cur_reg) begin
                    rd_en           = 1'b1;
                    rd_addr         = ga_reg[AW-1:0];
                    pend_addr_next  = gf_reg[AW-1:0];
                    pend_valid_next = 1'b1;
                    gf_next         = gf_reg + 1'b1;
                    ga_next         = ga_reg + 1'b1;
                end else if (gf_reg > cur_reg) begin
                    rd_en           = 1'b1;
                    rd_addr         = gf_dec[AW-1:0];
                    pend_addr_next  = ga_dec[AW-1:0];
                    pend_valid_next = 1'b1;
                    gf_next         = gf_dec;
                    ga_next         = ga_dec;
                end else if (!pend_valid_reg) begin
                    state_next = ST_OP;
                end
            end

            ST_OP: begin
                if (cmd_reg == gbts_pkg::CMD_INSERT) begin
                    state_next = ST_DONE;
                    if (gf_reg == ga_reg) begin
                        res_status_next = gbts_pkg::STAT_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = gf_reg[AW-1:0];
                        wr_data = ch_reg;
                        gf_next = gf_reg + 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end else begin
                    // delete the character before the gap
                    rd_en    = 1'b1;
                    rd_addr  = gf_dec[AW-1:0];
                    gf_next  = gf_dec;
                    len_next = len_reg - 1'b1;
                    if (cur_reg == len_reg) begin
                        cur_next = len_reg - 1'b1;
                    end
                    state_next = ST_READ;
                end
            end

            ST_READ: begin
                res_char_next = rd_data;
                state_next    = ST_DONE;
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gf_reg         <= '0;
            ga_reg         <= CW'(gbts_pkg::CAPACITY);
            cur_reg        <= '0;
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gf_reg         <= gf_next;
            ga_reg         <= ga_next;
            cur_reg        <= cur_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        ch_reg         <= ch_next;
        pend_addr_reg  <= pend_addr_next;
        res_char_reg   <= res_char_next;
        res_status_reg <= res_status_next;
    end

    assign res.char_out    = res_char_reg;
    assign res.status      = res_status_reg;
    assign res.text_length = 7'(len_reg);
    assign res.cursor_pos  = 7'(cur_reg);

endmodule

[rtl/gap_buffer_text_store.sv]
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Sequence: move, advance, unused codes, refused deletes and out-of-range reads
//   go straight to the result state; a read passes through a read state; insert
//   first relocates the gap to the cursor, one character moved per cycle, then
//   writes; delete relocates the gap, then reads the removed character back.
// Throughput: one item at a time; the next item is taken the cycle after the
//   current result is loaded into the output register. Gap relocation sets
//   the worst case.
// Reset: synchronous active-low aresetn empties the text (gap spans the store).
// ----------------------------------------------------------------------------
module gap_buffer_text_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [15:0] s_position,
    input  logic [7:0]         s_char_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_char_out,
    output logic [1:0]         m_status,
    output logic [6:0]         m_text_length,
    output logic [6:0]         m_cursor_pos
);

    gbts_pkg::gbts_res_t res;
    logic                res_valid;
    logic                res_take;
    logic                m_valid_reg, m_valid_next;
    gbts_pkg::gbts_res_t out_reg;

    gbts_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_position (s_position),
        .s_char_in  (s_char_in),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // output register
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (res_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_char_out    = out_reg.char_out;
    assign m_status      = out_reg.status;
    assign m_text_length = out_reg.text_length;
    assign m_cursor_pos  = out_reg.cursor_pos;

    // checks
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == gbts_pkg::STAT_FULL)
            |-> (m_text_length == 7'(gbts_pkg::CAPACITY)))
        else $error("full status with text not at capacity");

    a_cursor_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_pos <= m_text_length))
        else $error("cursor beyond text length");

    a_nodel_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == gbts_pkg::STAT_NODEL) |-> (m_cursor_pos == 7'd0))
        else $error("nothing-to-delete with cursor not at zero");

    a_fail_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != gbts_pkg::STAT_OK) |-> (m_char_out == 8'd0))
        else $error("failed command returned a character");

endmodule

[tb/sv/gap_buffer_text_store_test.sv]
// ----------------------------------------------------------------------------
// gap_buffer_text_store_test
// Self-checking testbench for the gap buffer text store. A behavioral model
// keeps the text as a plain character array and predicts every result item.
// Directed items cover the empty store, the cursor clamps, the field extremes
// and the unused commands. Random editing runs grow, shrink and mixed stretches
// under three sender/receiver idle settings.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused command codes: the block treats them as no-ops
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {EDIT_GROW, EDIT_SHRINK, EDIT_MIXED} edit_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd = gbts_pkg::CMD_MOVE;
    logic signed [15:0] s_position = '0;
    logic [7:0]         s_char_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_char_out;
    logic [1:0]         m_status;
    logic [6:0]         m_text_length;
    logic [6:0]         m_cursor_pos;

    // Text model: logical characters, no gap needed to predict the outputs
    logic [7:0] model_text [gbts_pkg::CAPACITY];
    int         model_len = 0;
    int         model_cursor = 0;

    gbts_pkg::gbts_res_t  pending_text_results [$];
    gbts_pkg::gbts_res_t  got_result;
    gbts_pkg::gbts_res_t  want_result;

    int sender_idle_pct = 23;
    int receiver_idle_pct = 77;
    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int full_drops = 0;
    int refused_deletes = 0;
    int range_reads = 0;
    int cycle_count;

    always #5 aclk = ~aclk;

    gap_buffer_text_store dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_char_in     (s_char_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_status      (m_status),
        .m_text_length (m_text_length),
        .m_cursor_pos  (m_cursor_pos)
    );

    // Clamp a cursor target to 0..length
    function automatic int clamp_to_text(input int target);
        if (target < 0) return 0;
        if (target > model_len) return model_len;
        return target;
    endfunction

    // Apply one command to the text model and return the result it produces
    function automatic gbts_pkg::gbts_res_t apply_text_command(
        input logic [2:0] cmd,
        input logic signed [15:0] pos,
        input logic [7:0] ch
    );
        gbts_pkg::gbts_res_t res;
        int        p;
        int        i;
        p = pos;
        res.char_out = '0;
        res.status   = gbts_pkg::STAT_OK;
        case (cmd)
            gbts_pkg::CMD_MOVE: begin
                model_cursor = clamp_to_text(p);
            end
            gbts_pkg::CMD_ADVANCE: begin
                model_cursor = clamp_to_text(model_cursor + p);
            end
            gbts_pkg::CMD_INSERT: begin
                if (model_len >= gbts_pkg::CAPACITY) begin
                    res.status = gbts_pkg::STAT_FULL;
                    full_drops++;
                end else begin
                    for (i = model_len; i > model_cursor; i--)
                        model_text[i] = model_text[i - 1];
                    model_text[model_cursor] = ch;
                    model_len++;
                end
            end
            gbts_pkg::CMD_DELETE: begin
                if (model_cursor == 0 || model_len == 0) begin
                    res.status = gbts_pkg::STAT_NODEL;
                    refused_deletes++;
                end else begin
                    // removes the character just before the cursor; cursor stays put unless past the new length
                    res.char_out = model_text[model_cursor - 1];
                    for (i = model_cursor - 1; i < model_len - 1; i++)
                        model_text[i] = model_text[i + 1];
                    model_len--;
                    if (model_cursor > model_len) model_cursor = model_len;
                end
            end
            gbts_pkg::CMD_READ: begin
                if (p < 0 || p >= model_len) begin
                    res.status = gbts_pkg::STAT_RANGE;
                    range_reads++;
                end else begin
                    res.char_out = model_text[p];
                end
            end
            default: ;
        endcase
        res.text_length = model_len[6:0];
        res.cursor_pos  = model_cursor[6:0];
        return res;
    endfunction

    // Present one item, with a random lead-in gap, and wait until it is taken
    task automatic send_text_cmd(input logic [2:0] cmd, input logic signed [15:0] pos,
                                 input logic [7:0] ch);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        pending_text_results.push_back(apply_text_command(cmd, pos, ch));
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= pos;
        s_char_in  <= ch;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has arrived
    task automatic wait_for_results;
        s_valid <= 1'b0;
        while (pending_text_results.size() != 0) @(posedge aclk);
    endtask

    // Result checker and random receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result.char_out    = m_char_out;
            got_result.status      = m_status;
            got_result.text_length = m_text_length;
            got_result.cursor_pos  = m_cursor_pos;
            if (pending_text_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: char %0h status %0d len %0d cursor %0d",
                             m_char_out, m_status, m_text_length, m_cursor_pos);
            end else begin
                want_result = pending_text_results.pop_front();
                results_checked++;
                if (got_result.char_out !== want_result.char_out ||
                    got_result.status !== want_result.status ||
                    got_result.text_length !== want_result.text_length ||
                    got_result.cursor_pos !== want_result.cursor_pos) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result %0d mismatch: char %0h/%0h status %0d/%0d ",
                                  "len %0d/%0d cursor %0d/%0d (expected/actual)"},
                                 results_checked,
                                 want_result.char_out, got_result.char_out,
                                 want_result.status, got_result.status,
                                 want_result.text_length, got_result.text_length,
                                 want_result.cursor_pos, got_result.cursor_pos);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Empty store: reads and deletes are refused, cursor pinned at zero
    task automatic test_empty_store_cases;
        send_text_cmd(gbts_pkg::CMD_READ, 16'sd0, 8'h00);
        send_text_cmd(gbts_pkg::CMD_DELETE, 16'sd0, 8'hFF);
        send_text_cmd(gbts_pkg::CMD_MOVE, 16'sh7FFF, 8'h00);
        send_text_cmd(gbts_pkg::CMD_ADVANCE, -16'sh8000, 8'h00);
        send_text_cmd(gbts_pkg::CMD_READ, -16'sh8000, 8'h00);
    endtask

    // Insert extremes of the character, read them back, delete one
    task automatic test_insert_delete_read;
        send_text_cmd(gbts_pkg::CMD_INSERT, 16'sd0, 8'h00);
        send_text_cmd(gbts_pkg::CMD_INSERT, -16'sd1, 8'hFF);
        send_text_cmd(gbts_pkg::CMD_INSERT, 16'sh7FFF, 8'hA5);
        send_text_cmd(gbts_pkg::CMD_READ, 16'sd0, 8'h5A);
        send_text_cmd(gbts_pkg::CMD_READ, 16'sd2, 8'h00);
        send_text_cmd(gbts_pkg::CMD_READ, 16'sd3, 8'h00);
        send_text_cmd(gbts_pkg::CMD_READ, -16'sd1, 8'h00);
        send_text_cmd(gbts_pkg::CMD_MOVE, 16'sh7FFF, 8'h00);
        // cursor at the end: delete pulls it back to the new length
        send_text_cmd(gbts_pkg::CMD_DELETE, 16'sd0, 8'h00);
        send_text_cmd(gbts_pkg::CMD_READ, 16'sh7FFF, 8'h00);
    endtask

    // Cursor clamps, and a refused delete with text present
    task automatic test_cursor_clamping;
        send_text_cmd(gbts_pkg::CMD_MOVE, -16'sh8000, 8'h00);
        send_text_cmd(gbts_pkg::CMD_DELETE, 16'sd0, 8'h00);
        send_text_cmd(gbts_pkg::CMD_ADVANCE, 16'sh7FFF, 8'h00);
        send_text_cmd(gbts_pkg::CMD_ADVANCE, -16'sd1, 8'h00);
        send_text_cmd(gbts_pkg::CMD_ADVANCE, -16'sh8000, 8'h00);
    endtask

    // Spare command codes change nothing
    task automatic test_unused_commands;
        send_text_cmd(CMD_SPARE_A, 16'($urandom), 8'($urandom));
        send_text_cmd(CMD_SPARE_B, 16'($urandom), 8'($urandom));
        send_text_cmd(CMD_SPARE_C, 16'($urandom), 8'($urandom));
    endtask

    // One random edit, weighted by the current stretch
    task automatic random_edit(input edit_mode_t mode);
        int                 roll;
        int                 ins_w;
        int                 del_w;
        int                 mov_w;
        int                 adv_w;
        logic signed [15:0] pos;
        roll = $urandom_range(99);
        case (mode)
            EDIT_GROW:   begin ins_w = 75; del_w = 5;  mov_w = 5;  adv_w = 5;  end
            EDIT_SHRINK: begin ins_w = 5;  del_w = 65; mov_w = 10; adv_w = 5;  end
            default:     begin ins_w = 30; del_w = 25; mov_w = 10; adv_w = 10; end
        endcase
        if (roll < 5) begin
            // noise: any code, any field value
            send_text_cmd(3'($urandom), 16'($urandom), 8'($urandom));
        end else if (roll < 5 + ins_w) begin
            send_text_cmd(gbts_pkg::CMD_INSERT, 16'($urandom), 8'($urandom));
        end else if (roll < 5 + ins_w + del_w) begin
            send_text_cmd(gbts_pkg::CMD_DELETE, 16'($urandom), 8'($urandom));
        end else if (roll < 5 + ins_w + del_w + mov_w) begin
            if ($urandom_range(99) < 85) pos = 16'(int'($urandom_range(model_len + 4)) - 2);
            else pos = 16'($urandom);
            send_text_cmd(gbts_pkg::CMD_MOVE, pos, 8'($urandom));
        end else if (roll < 5 + ins_w + del_w + mov_w + adv_w) begin
            if ($urandom_range(99) < 85) pos = 16'(int'($urandom_range(16)) - 8);
            else pos = 16'($urandom);
            send_text_cmd(gbts_pkg::CMD_ADVANCE, pos, 8'($urandom));
        end else begin
            roll = $urandom_range(99);
            if (roll < 80 && model_len > 0) pos = 16'($urandom_range(model_len - 1));
            else if (roll < 95) pos = 16'(int'($urandom_range(model_len + 4)) - 2);
            else pos = 16'($urandom);
            send_text_cmd(gbts_pkg::CMD_READ, pos, 8'($urandom));
        end
    endtask

    // Random editing: a grow stretch that reaches full, then shrink, then mixed
    task automatic test_random_editing(input int n_items);
        int i;
        for (i = 0; i < n_items; i++) begin
            if (i < 110) random_edit(EDIT_GROW);
            else if (i < 170) random_edit(EDIT_SHRINK);
            else random_edit(EDIT_MIXED);
        end
    endtask

    initial begin
        foreach (model_text[i]) model_text[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_store_cases();
        test_insert_delete_read();
        test_cursor_clamping();
        test_unused_commands();

        test_random_editing(210);
        wait_for_results();

        sender_idle_pct   = 77;
        receiver_idle_pct = 23;
        test_random_editing(210);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_editing(210);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatch_count);
        $display("full inserts dropped %0d, refused deletes %0d, out-of-range reads %0d",
                 full_drops, refused_deletes, range_reads);
        if (mismatch_count == 0 && pending_text_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
